/* rtl/afr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// afr_pkg: shared types and constants of the address-filtered frame receiver
// Holds the frame flags, the event codes, the phase type, the register
// indexes and the structs passed between the receiver modules.
// ----------------------------------------------------------------------------
package afr_pkg;

  // Field widths.
  localparam int ByteW      = 8;
  localparam int EventW     = 3;
  localparam int StationIdW = 24;
  localparam int MaxLenW    = 8;
  localparam int CountOutW  = 16;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 24;

  // The identifier is looked up as a zero-padded 8-byte word.
  localparam int IdExtW     = 64;
  localparam int IdPosMaxW  = 3;

  // Frame delimiters.
  localparam logic [ByteW-1:0] StartFlag = 8'h01;
  localparam logic [ByteW-1:0] EndFlag   = 8'h06;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegStationId = 1'd0;
  localparam logic [CfgIdxW-1:0] RegMaxLen    = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [StationIdW-1:0] StationIdReset = 24'd0;
  localparam logic [MaxLenW-1:0]    MaxLenReset    = 8'd64;

  typedef enum logic [1:0] {
    PhHunt,
    PhAddr,
    PhPayload,
    PhSkip
  } phase_e;

  typedef enum logic [EventW-1:0] {
    EvIgnored  = 3'd0,
    EvAddress  = 3'd1,
    EvStored   = 3'd2,
    EvDropped  = 3'd3,
    EvAccepted = 3'd4,
    EvRejected = 3'd5,
    EvSkipped  = 3'd6
  } event_e;

  typedef struct packed {
    logic [StationIdW-1:0] station_id;
    logic [MaxLenW-1:0]    max_len;
  } cfg_t;

  typedef struct packed {
    event_e           event_res;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] write_index;
    logic [ByteW-1:0] message_len;
  } result_t;

endpackage
`default_nettype wire

/* rtl/afr_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// afr_if: request channels of the frame receiver
// One interface for the received byte stream and one for the result stream,
// each with valid, ready and its payload.
// ----------------------------------------------------------------------------
interface afr_in_if;
  logic                        valid;
  logic                        ready;
  logic [afr_pkg::ByteW-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afr_out_if;
  logic                          valid;
  logic                          ready;
  logic [afr_pkg::EventW-1:0]    event_res;
  logic [afr_pkg::ByteW-1:0]     payload_byte;
  logic [afr_pkg::ByteW-1:0]     write_index;
  logic [afr_pkg::ByteW-1:0]     message_len;
  logic [afr_pkg::CountOutW-1:0] accepted_frames;
  logic [afr_pkg::CountOutW-1:0] rejected_frames;

  modport source (
    output valid, output event_res, output payload_byte, output write_index,
    output message_len, output accepted_frames, output rejected_frames,
    input ready
  );
  modport sink (
    input valid, input event_res, input payload_byte, input write_index,
    input message_len, input accepted_frames, input rejected_frames,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/afr_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// afr_cfg_regs: configuration registers
// Decodes the register index of the write port and holds the station
// identifier and the largest stored message length.
// ----------------------------------------------------------------------------
module afr_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [afr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [afr_pkg::CfgDataW-1:0]   cfg_data_i,
  output afr_pkg::cfg_t                       cfg_o
);

  logic [afr_pkg::StationIdW-1:0] station_id_q;
  logic [afr_pkg::MaxLenW-1:0]    max_len_q;

  // Register writes, selected by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_id_q <= afr_pkg::StationIdReset;
      max_len_q    <= afr_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        afr_pkg::RegStationId: station_id_q <= cfg_data_i[afr_pkg::StationIdW-1:0];
        afr_pkg::RegMaxLen:    max_len_q    <= cfg_data_i[afr_pkg::MaxLenW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.station_id = station_id_q;
  assign cfg_o.max_len    = max_len_q;

endmodule
`default_nettype wire

/* rtl/afr_fsm.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// afr_fsm: frame parser state and per-byte step
// Holds the frame phase, address match, store length and frame counters,
// and works out the result of one byte in combinational logic.
// ----------------------------------------------------------------------------
module afr_fsm #(
  parameter int COUNT_WIDTH = 16,
  parameter int ID_BYTES    = 3
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [afr_pkg::ByteW-1:0]   byte_i,
  input  afr_pkg::cfg_t                    cfg_i,
  output afr_pkg::result_t                 result_o,
  output logic [COUNT_WIDTH-1:0]           accepted_o,
  output logic [COUNT_WIDTH-1:0]           rejected_o
);

  localparam int PosW = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(ID_BYTES - 1);

  afr_pkg::phase_e         phase_q, phase_d;
  logic                    match_q, match_d;
  logic [PosW-1:0]         pos_q, pos_d;
  logic [afr_pkg::ByteW-1:0] len_q, len_d;
  logic [COUNT_WIDTH-1:0]  acc_q, acc_d;
  logic [COUNT_WIDTH-1:0]  rej_q, rej_d;

  logic [afr_pkg::IdExtW-1:0]   id_ext;
  logic [afr_pkg::IdPosMaxW-1:0] pos_ext;
  logic [afr_pkg::ByteW-1:0]    want;
  logic                         match_now;

  // Identifier byte expected at the current address position.
  assign id_ext    = afr_pkg::IdExtW'(cfg_i.station_id);
  assign pos_ext   = afr_pkg::IdPosMaxW'(pos_q);
  assign want      = id_ext[{pos_ext, 3'b000} +: afr_pkg::ByteW];
  assign match_now = match_q && (byte_i == want);

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_d = phase_q;
    match_d = match_q;
    pos_d   = pos_q;
    len_d   = len_q;
    acc_d   = acc_q;
    rej_d   = rej_q;
    result_o.event_res    = afr_pkg::EvIgnored;
    result_o.payload_byte = '0;
    result_o.write_index  = '0;
    case (phase_q)
      afr_pkg::PhHunt: begin
        if (byte_i == afr_pkg::StartFlag) begin
          match_d = 1'b1;
          pos_d   = '0;
          phase_d = afr_pkg::PhAddr;
        end
      end
      afr_pkg::PhAddr: begin
        result_o.event_res = afr_pkg::EvAddress;
        match_d = match_now;
        if (pos_q == LastPos) begin
          pos_d = '0;
          if (match_now) begin
            len_d   = '0;
            phase_d = afr_pkg::PhPayload;
          end else begin
            phase_d = afr_pkg::PhSkip;
          end
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
      afr_pkg::PhPayload: begin
        if (byte_i == afr_pkg::EndFlag) begin
          result_o.event_res = afr_pkg::EvAccepted;
          acc_d   = acc_q + COUNT_WIDTH'(1);
          phase_d = afr_pkg::PhHunt;
        end else if (len_q < cfg_i.max_len) begin
          result_o.event_res    = afr_pkg::EvStored;
          result_o.payload_byte = byte_i;
          result_o.write_index  = len_q;
          len_d = len_q + 8'd1;
        end else begin
          result_o.event_res = afr_pkg::EvDropped;
        end
      end
      default: begin
        if (byte_i == afr_pkg::EndFlag) begin
          result_o.event_res = afr_pkg::EvRejected;
          rej_d   = rej_q + COUNT_WIDTH'(1);
          phase_d = afr_pkg::PhHunt;
        end else begin
          result_o.event_res = afr_pkg::EvSkipped;
        end
      end
    endcase
    result_o.message_len = len_d;
  end

  assign accepted_o = acc_d;
  assign rejected_o = rej_d;

  // State registers advance once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= afr_pkg::PhHunt;
      match_q <= 1'b1;
      pos_q   <= '0;
      len_q   <= '0;
      acc_q   <= '0;
      rej_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      match_q <= match_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      acc_q   <= acc_d;
      rej_q   <= rej_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/address_filtered_frame_receiver_unit.sv */
`default_nettype none
// Pipeline: a byte taken from the receive channel is held in the input register,
// then its result is written into the result register, which drives res_o.
// Throughput: one byte per cycle while the result is not stalled; the parser
// step is combinational logic between the input register and the result register.
// A stalled result holds the input register; a new byte is still taken while
// the input register is free.
// Reset: parser back to hunting, counters and length cleared, max length 64.
// ----------------------------------------------------------------------------
// address_filtered_frame_receiver_unit: address-filtered frame receiver
// Parses a flagged byte stream, matches the station identifier and reports
// one event per received byte with the store position and frame counters.
// ----------------------------------------------------------------------------
module address_filtered_frame_receiver_unit #(
  parameter int COUNT_WIDTH = 16,
  parameter int ID_BYTES    = 3
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  afr_in_if.sink                            rx_i,
  afr_out_if.source                         res_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [afr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [afr_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int CntOutW = afr_pkg::CountOutW;

  afr_pkg::cfg_t             cfg;
  afr_pkg::result_t          result;
  logic [COUNT_WIDTH-1:0]    accepted;
  logic [COUNT_WIDTH-1:0]    rejected;

  logic                      in_valid_q;
  logic [afr_pkg::ByteW-1:0] in_byte_q;
  logic                      out_valid_q;
  afr_pkg::result_t          out_res_q;
  logic [CntOutW-1:0]        out_acc_q;
  logic [CntOutW-1:0]        out_rej_q;
  logic                      advance;
  logic                      step;

  afr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  afr_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .ID_BYTES    (ID_BYTES)
  ) u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .cfg_i      (cfg),
    .result_o   (result),
    .accepted_o (accepted),
    .rejected_o (rejected)
  );

  // Pipeline control: the result register moves when empty or taken.
  assign advance     = !out_valid_q || res_o.ready;
  assign step        = in_valid_q && advance;
  assign rx_i.ready  = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= result;
      out_acc_q <= CntOutW'(accepted);
      out_rej_q <= CntOutW'(rejected);
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.event_res       = out_res_q.event_res;
  assign res_o.payload_byte    = out_res_q.payload_byte;
  assign res_o.write_index     = out_res_q.write_index;
  assign res_o.message_len     = out_res_q.message_len;
  assign res_o.accepted_frames = out_acc_q;
  assign res_o.rejected_frames = out_rej_q;

  // A stored byte always advances the length by one past its write index.
  a_store_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.event_res == afr_pkg::EvStored) |->
      (res_o.message_len == res_o.write_index + 8'd1))
    else $error("stored byte length mismatch");

  // A full pipeline with a stalled result must not take a new byte.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && res_o.valid && !res_o.ready) |-> !rx_i.ready)
    else $error("byte accepted while pipeline is full");

  // A result that is not taken holds its event.
  a_hold_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> (res_o.valid && $stable(res_o.event_res)))
    else $error("stalled result changed");

  // Only a stored byte carries payload.
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.event_res != afr_pkg::EvStored) |->
      (res_o.payload_byte == 8'd0 && res_o.write_index == 8'd0))
    else $error("payload on non-store event");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: frame receiver event stream check
// Drives flagged byte frames into the receiver with random idle and stall
// cycles. A parser model predicts the event for every accepted byte. Each
// reported event is compared with the oldest prediction. The run covers
// several identifier and length settings, among them a frame that runs past
// the largest message length.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          ByteW       = afr_pkg::ByteW;
  localparam int          StationIdW  = afr_pkg::StationIdW;
  localparam int          MaxLenW     = afr_pkg::MaxLenW;
  localparam int          CountOutW   = afr_pkg::CountOutW;
  localparam int          CfgIdxW     = afr_pkg::CfgIdxW;
  localparam int          CfgDataW    = afr_pkg::CfgDataW;
  localparam int          CountWidth  = 16;
  localparam int          IdBytes     = 3;
  localparam int          ClkHalf     = 6;
  localparam int          ResetCycles = 12;
  localparam int          DrainCycles = 8;
  localparam int unsigned CycleLimit  = 200_000;

  // One reported event with the counters that follow it.
  typedef struct packed {
    afr_pkg::event_e        ev;
    logic [ByteW-1:0]       payload;
    logic [ByteW-1:0]       widx;
    logic [ByteW-1:0]       len;
    logic [CountOutW-1:0]   accepted;
    logic [CountOutW-1:0]   rejected;
  } frame_event_t;

  // Parser model and the queue of events it has predicted.
  class frame_event_board;
    logic [StationIdW-1:0]  station_id;
    logic [MaxLenW-1:0]     max_len;
    afr_pkg::phase_e        phase;
    bit                     id_match;
    int unsigned            addr_pos;
    logic [ByteW-1:0]       stored_len;
    logic [CountWidth-1:0]  accepted_cnt;
    logic [CountWidth-1:0]  rejected_cnt;
    frame_event_t           upcoming_events[$];
    int unsigned            mismatches;

    function new();
      station_id   = afr_pkg::StationIdReset;
      max_len      = afr_pkg::MaxLenReset;
      phase        = afr_pkg::PhHunt;
      id_match     = 1'b1;
      addr_pos     = 0;
      stored_len   = '0;
      accepted_cnt = '0;
      rejected_cnt = '0;
      mismatches   = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == afr_pkg::RegStationId) begin
        station_id = data[StationIdW-1:0];
      end else if (idx == afr_pkg::RegMaxLen) begin
        max_len = data[MaxLenW-1:0];
      end
    endfunction

    // Advance the parser by one accepted byte and queue the event it causes.
    function void note_byte(logic [ByteW-1:0] b);
      frame_event_t     ev;
      logic [ByteW-1:0] id_byte;
      ev.ev      = afr_pkg::EvIgnored;
      ev.payload = '0;
      ev.widx    = '0;
      case (phase)
        afr_pkg::PhHunt: begin
          if (b == afr_pkg::StartFlag) begin
            id_match = 1'b1;
            addr_pos = 0;
            phase    = afr_pkg::PhAddr;
          end
        end
        afr_pkg::PhAddr: begin
          id_byte = station_id[8*addr_pos +: 8];
          ev.ev   = afr_pkg::EvAddress;
          if (b != id_byte) id_match = 1'b0;
          if (addr_pos + 1 >= IdBytes) begin
            addr_pos = 0;
            if (id_match) begin
              stored_len = '0;
              phase      = afr_pkg::PhPayload;
            end else begin
              phase = afr_pkg::PhSkip;
            end
          end else begin
            addr_pos++;
          end
        end
        afr_pkg::PhPayload: begin
          if (b == afr_pkg::EndFlag) begin
            ev.ev        = afr_pkg::EvAccepted;
            accepted_cnt = accepted_cnt + 1'b1;
            phase        = afr_pkg::PhHunt;
          end else if (stored_len < max_len) begin
            ev.ev      = afr_pkg::EvStored;
            ev.payload = b;
            ev.widx    = stored_len;
            stored_len = stored_len + 1'b1;
          end else begin
            ev.ev = afr_pkg::EvDropped;
          end
        end
        default: begin
          if (b == afr_pkg::EndFlag) begin
            ev.ev        = afr_pkg::EvRejected;
            rejected_cnt = rejected_cnt + 1'b1;
            phase        = afr_pkg::PhHunt;
          end else begin
            ev.ev = afr_pkg::EvSkipped;
          end
        end
      endcase
      ev.len      = stored_len;
      ev.accepted = accepted_cnt[CountOutW-1:0];
      ev.rejected = rejected_cnt[CountOutW-1:0];
      upcoming_events.push_back(ev);
    endfunction

    function int unsigned pending();
      return upcoming_events.size();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
    endfunction

    // Compare one reported event with the oldest prediction.
    function void check_event(frame_event_t got);
      frame_event_t want;
      if (upcoming_events.size() == 0) begin
        mismatches++;
        $error("event_res mismatch: expected none, actual %0d", got.ev);
        return;
      end
      want = upcoming_events.pop_front();
      compare_field("event_res", 32'(want.ev), 32'(got.ev));
      compare_field("payload_byte", 32'(want.payload), 32'(got.payload));
      compare_field("write_index", 32'(want.widx), 32'(got.widx));
      compare_field("message_len", 32'(want.len), 32'(got.len));
      compare_field("accepted_frames", 32'(want.accepted), 32'(got.accepted));
      compare_field("rejected_frames", 32'(want.rejected), 32'(got.rejected));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  bit                   rx_gaps_on;
  bit                   res_stalls_on;
  int unsigned          bytes_sent;
  int unsigned          cycle_count;
  frame_event_board     board;

  afr_in_if  rx_if ();
  afr_out_if res_if ();

  address_filtered_frame_receiver_unit #(
    .COUNT_WIDTH (CountWidth),
    .ID_BYTES    (IdBytes)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Free-running clock.
  always begin
    clk_i = 1'b0;
    #(ClkHalf);
    clk_i = 1'b1;
    #(ClkHalf);
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one byte after an optional gap and wait until the request is taken.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = rx_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    board.note_byte(b);
    bytes_sent++;
  endtask

  // Payload content: random, never the end flag, now and then the start flag.
  function automatic logic [ByteW-1:0] payload_byte();
    logic [ByteW-1:0] b;
    b = ByteW'($urandom_range(0, 255));
    if (b == afr_pkg::EndFlag || $urandom_range(0, 15) == 0) b = afr_pkg::StartFlag;
    return b;
  endfunction

  // One frame: start flag, identifier, payload and, if closed, the end flag.
  task automatic send_frame(input logic [StationIdW-1:0] id, input bit id_ok,
                            input int unsigned payload_len, input bit closed);
    logic [ByteW-1:0] b;
    int unsigned      bad_pos;
    int unsigned      i;
    bad_pos = $urandom_range(0, IdBytes - 1);
    send_byte(afr_pkg::StartFlag);
    for (i = 0; i < IdBytes; i++) begin
      b = id[8*i +: 8];
      if (!id_ok && i == bad_pos) b = b ^ ByteW'($urandom_range(1, 255));
      send_byte(b);
    end
    for (i = 0; i < payload_len; i++) begin
      send_byte(payload_byte());
    end
    if (closed) send_byte(afr_pkg::EndFlag);
  endtask

  // Let the block drain, then write both registers.
  task automatic configure(input logic [StationIdW-1:0] id, input logic [MaxLenW-1:0] max_len);
    rx_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= afr_pkg::RegStationId;
    cfg_data_i <= CfgDataW'(id);
    @(posedge clk_i);
    board.set_register(afr_pkg::RegStationId, CfgDataW'(id));
    cfg_idx_i  <= afr_pkg::RegMaxLen;
    cfg_data_i <= CfgDataW'(max_len);
    @(posedge clk_i);
    board.set_register(afr_pkg::RegMaxLen, CfgDataW'(max_len));
    cfg_we_i <= 1'b0;
  endtask

  // Mixed traffic: mostly good frames, some foreign, noise and broken ones.
  task automatic random_traffic(input logic [StationIdW-1:0] id, input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned i;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        rx_gaps_on    = $urandom_range(0, 2) != 0;
        res_stalls_on = $urandom_range(0, 2) != 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(id, 1'b1, $urandom_range(0, 10), 1'b1);
      end else if (pick < 80) begin
        send_frame(id, 1'b0, $urandom_range(0, 6), 1'b1);
      end else if (pick < 90) begin
        for (i = 0; i < $urandom_range(1, 4); i++) begin
          send_byte(ByteW'($urandom_range(0, 255)));
        end
      end else if (pick < 95) begin
        // Frame cut off before its end flag.
        send_frame(id, 1'($urandom_range(0, 1)), $urandom_range(0, 4), 1'b0);
      end else begin
        // Start flag followed by a partial identifier.
        send_byte(afr_pkg::StartFlag);
        send_byte(id[7:0]);
      end
    end
  endtask

  // Result side: random stall before each result, then check it.
  initial begin
    frame_event_t got;
    int unsigned  stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = res_stalls_on ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      got.ev       = afr_pkg::event_e'(res_if.event_res);
      got.payload  = res_if.payload_byte;
      got.widx     = res_if.write_index;
      got.len      = res_if.message_len;
      got.accepted = res_if.accepted_frames;
      got.rejected = res_if.rejected_frames;
      board.check_event(got);
    end
  end

  // Stimulus sequence.
  initial begin
    logic [StationIdW-1:0] id;
    board         = new();
    rx_gaps_on    = 1'b1;
    res_stalls_on = 1'b1;
    bytes_sent    = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = afr_pkg::RegStationId;
    cfg_data_i    = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: noise and an end flag while hunting, then a frame for
    // identifier zero that carries a start flag as payload.
    send_byte(8'h00);
    send_byte(afr_pkg::EndFlag);
    send_frame(24'h000000, 1'b1, 0, 1'b0);
    send_byte(afr_pkg::StartFlag);
    send_byte(afr_pkg::EndFlag);

    // Flag bytes inside the identifier, zero maximum so payload is dropped.
    configure(24'h060106, 8'd0);
    send_byte(afr_pkg::StartFlag);
    send_byte(afr_pkg::EndFlag);
    send_byte(afr_pkg::StartFlag);
    send_byte(afr_pkg::EndFlag);
    send_byte(8'hFF);
    send_byte(afr_pkg::EndFlag);

    // Foreign frame with a start flag inside; length from before is kept.
    send_byte(afr_pkg::StartFlag);
    send_byte(afr_pkg::EndFlag);
    send_byte(afr_pkg::StartFlag);
    send_byte(8'h07);
    send_byte(afr_pkg::StartFlag);
    send_byte(afr_pkg::EndFlag);

    // Random traffic over several settings, the extremes among them.
    id = StationIdW'($urandom);
    configure(id, MaxLenW'($urandom_range(1, 8)));
    random_traffic(id, 50);

    configure(24'hFFFFFF, 8'd255);
    random_traffic(24'hFFFFFF, 25);
    send_frame(24'hFFFFFF, 1'b1, 258, 1'b1);
    random_traffic(24'hFFFFFF, 15);

    configure(24'h000000, 8'd0);
    random_traffic(24'h000000, 35);

    id = StationIdW'($urandom);
    configure(id, MaxLenW'($urandom_range(0, 255)));
    random_traffic(id, 35);

    id = StationIdW'($urandom);
    configure(id, 8'd1);
    random_traffic(id, 30);

    // A little more traffic with a short maximum.
    id = StationIdW'($urandom);
    configure(id, MaxLenW'($urandom_range(1, 16)));
    random_traffic(id, 30);

    rx_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* address_filtered_frame_receiver_unit.f */
rtl/afr_pkg.sv
rtl/afr_if.sv
rtl/afr_cfg_regs.sv
rtl/afr_fsm.sv
rtl/address_filtered_frame_receiver_unit.sv
tb/testbench.sv
